[src/kufef_pkg.sv]
// ----------------------------------------------------------------------------
// kufef_pkg
// Shared types and constants for the union-find edge filter.
// ----------------------------------------------------------------------------
package kufef_pkg;

    localparam int NODE_W   = 4;
    localparam int WEIGHT_W = 16;
    localparam int COUNT_W  = 4;
    localparam int COST_W   = 20;
    localparam int VC_W     = 5;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [COST_W-1:0]  COST_MAX  = '1;
    localparam logic [VC_W-1:0]    VC_RESET  = 5'd16;

    // Register index decoded from paddr[2].
    localparam logic REG_VERTEX_COUNT = 1'b0;

    typedef struct packed {
        logic load_item;
        logic start_a;
        logic start_b;
        logic walk;
        logic latch_ra;
        logic latch_rb;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic walk_done;
        logic a_ok;
        logic b_ok;
        logic out_free;
    } dp_status_t;

endpackage

[src/kufef_if.sv]
// ----------------------------------------------------------------------------
// kufef_edge_if / kufef_result_if
// Valid-ready channels for edge requests and filter results.
// ----------------------------------------------------------------------------
interface kufef_edge_if;
    logic                           valid;
    logic                           ready;
    logic [kufef_pkg::NODE_W-1:0]   node_a;
    logic [kufef_pkg::NODE_W-1:0]   node_b;
    logic [kufef_pkg::WEIGHT_W-1:0] edge_weight;

    modport source (output valid, node_a, node_b, edge_weight, input ready);
    modport sink (input valid, node_a, node_b, edge_weight, output ready);
endinterface

interface kufef_result_if;
    logic                          valid;
    logic                          ready;
    logic                          accepted;
    logic [kufef_pkg::NODE_W-1:0]  root_a;
    logic [kufef_pkg::NODE_W-1:0]  root_b;
    logic [kufef_pkg::COUNT_W-1:0] tree_edges;
    logic [kufef_pkg::COST_W-1:0]  total_cost;
    logic                          tree_complete;

    modport source (output valid, accepted, root_a, root_b, tree_edges, total_cost,
                    tree_complete, input ready);
    modport sink (input valid, accepted, root_a, root_b, tree_edges, total_cost,
                  tree_complete, output ready);
endinterface

[src/kufef_ctrl.sv]
// ----------------------------------------------------------------------------
// kufef_ctrl
// Sequencer for one edge: a root walk for each endpoint in range, then the commit of the result.
// ----------------------------------------------------------------------------
module kufef_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  kufef_pkg::dp_status_t status,
    output kufef_pkg::ctrl_cmd_t  cmd
);
    import kufef_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START_A,
        ST_WALK_A,
        ST_START_B,
        ST_WALK_B,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_START_A;
                end
            end
            ST_START_A:
            begin
                cmd.start_a = 1'b1;
                state_next  = status.a_ok ? ST_WALK_A : ST_START_B;
            end
            ST_WALK_A:
            begin
                cmd.walk = 1'b1;
                if (status.walk_done)
                begin
                    cmd.latch_ra = 1'b1;
                    state_next   = ST_START_B;
                end
            end
            ST_START_B:
            begin
                cmd.start_b = 1'b1;
                state_next  = status.b_ok ? ST_WALK_B : ST_COMMIT;
            end
            ST_WALK_B:
            begin
                cmd.walk = 1'b1;
                if (status.walk_done)
                begin
                    cmd.latch_rb = 1'b1;
                    state_next   = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[src/kufef_dp.sv]
// ----------------------------------------------------------------------------
// kufef_dp
// Parent table, root walk unit, counters and result register.
// ----------------------------------------------------------------------------
module kufef_dp #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  kufef_pkg::ctrl_cmd_t            cmd,
    output kufef_pkg::dp_status_t           status,
    input  logic [kufef_pkg::VC_W-1:0]      vertex_count,
    input  logic [kufef_pkg::NODE_W-1:0]    node_a,
    input  logic [kufef_pkg::NODE_W-1:0]    node_b,
    input  logic [kufef_pkg::WEIGHT_W-1:0]  edge_weight,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            accepted,
    output logic [kufef_pkg::NODE_W-1:0]    root_a,
    output logic [kufef_pkg::NODE_W-1:0]    root_b,
    output logic [kufef_pkg::COUNT_W-1:0]   tree_edges,
    output logic [kufef_pkg::COST_W-1:0]    total_cost,
    output logic                            tree_complete
);
    import kufef_pkg::*;

    localparam int IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int STEP_W = $clog2(MAX_VERTICES + 1);
    localparam int NW = ($clog2(MAX_VERTICES + 1) > VC_W) ? $clog2(MAX_VERTICES + 1) : VC_W;
    localparam logic [NW-1:0] N_MIN = NW'(2);
    localparam logic [NW-1:0] N_MAX = NW'(MAX_VERTICES);
    localparam logic [STEP_W-1:0] STEP_LIMIT = STEP_W'(MAX_VERTICES);

    logic [IDX_W-1:0]    mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] vld_reg;
    logic [IDX_W-1:0]    rd_q;
    logic                rd_vld_q;
    logic [IDX_W-1:0]    rd_addr;

    logic [NODE_W-1:0]   a_reg;
    logic [NODE_W-1:0]   b_reg;
    logic [WEIGHT_W-1:0] w_reg;
    logic [IDX_W-1:0]    cur_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [NODE_W-1:0]   ra_reg;
    logic [NODE_W-1:0]   rb_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [COST_W-1:0]   cost_reg;
    logic                out_valid_reg;

    logic [NW-1:0]       eff_n;
    logic [NW-1:0]       vc_ext;
    logic [IDX_W-1:0]    up;
    logic                take;
    logic [COUNT_W-1:0]  count_next;
    logic [COST_W-1:0]   cost_next;
    logic [COST_W:0]     cost_sum;

    function automatic logic is_complete(input logic [COUNT_W-1:0] cnt,
                                         input logic [NW-1:0] n);
        logic [NW-1:0] cnt_ext;
        cnt_ext = NW'(cnt);
        return cnt_ext >= (n - NW'(1));
    endfunction

    assign vc_ext = NW'(vertex_count);

    always_comb
    begin
        priority if (vc_ext < N_MIN)
        begin
            eff_n = N_MIN;
        end
        else if (vc_ext > N_MAX)
        begin
            eff_n = N_MAX;
        end
        else
        begin
            eff_n = vc_ext;
        end
    end

    assign up = rd_vld_q ? rd_q : cur_reg;

    assign status.walk_done = (up == cur_reg) || (step_reg == STEP_LIMIT);
    assign status.a_ok      = NW'(a_reg) < eff_n;
    assign status.b_ok      = NW'(b_reg) < eff_n;
    assign status.out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        priority if (cmd.start_a)
        begin
            rd_addr = IDX_W'(a_reg);
        end
        else if (cmd.start_b)
        begin
            rd_addr = IDX_W'(b_reg);
        end
        else
        begin
            rd_addr = up;
        end
    end

    assign take = status.a_ok && status.b_ok && (ra_reg != rb_reg)
                  && !is_complete(count_reg, eff_n);
    assign cost_sum = {1'b0, cost_reg} + (COST_W + 1)'(w_reg);

    always_comb
    begin
        count_next = count_reg;
        cost_next  = cost_reg;
        if (take)
        begin
            if (count_reg != COUNT_MAX)
            begin
                count_next = count_reg + COUNT_W'(1);
            end
            cost_next = cost_sum[COST_W] ? COST_MAX : cost_sum[COST_W-1:0];
        end
    end

    // Parent table: registered read, single write port.
    always_ff @(posedge clk)
    begin
        rd_q <= mem[rd_addr];
        if (cmd.commit && take)
        begin
            mem[IDX_W'(ra_reg)] <= IDX_W'(rb_reg);
        end
    end

    // An entry that was never written is its own parent.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rd_vld_q <= 1'b0;
        end
        else
        begin
            rd_vld_q <= vld_reg[rd_addr];
            if (cmd.commit && take)
            begin
                vld_reg[IDX_W'(ra_reg)] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            a_reg <= node_a;
            b_reg <= node_b;
            w_reg <= edge_weight;
        end
        if (cmd.start_a)
        begin
            cur_reg <= IDX_W'(a_reg);
            ra_reg  <= a_reg;
        end
        else if (cmd.start_b)
        begin
            cur_reg <= IDX_W'(b_reg);
            rb_reg  <= b_reg;
        end
        else if (cmd.walk && !status.walk_done)
        begin
            cur_reg <= up;
        end
        if (cmd.latch_ra)
        begin
            ra_reg <= NODE_W'(cur_reg);
        end
        if (cmd.latch_rb)
        begin
            rb_reg <= NODE_W'(cur_reg);
        end
        if (cmd.commit)
        begin
            accepted      <= take;
            root_a        <= ra_reg;
            root_b        <= rb_reg;
            tree_edges    <= count_next;
            total_cost    <= cost_next;
            tree_complete <= is_complete(count_next, eff_n);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            count_reg     <= '0;
            cost_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start_a || cmd.start_b)
            begin
                step_reg <= '0;
            end
            else if (cmd.walk && !status.walk_done)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
            if (cmd.commit)
            begin
                count_reg     <= count_next;
                cost_reg      <= cost_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[src/kruskal_union_find_edge_filter.sv]
// ----------------------------------------------------------------------------
// kruskal_union_find_edge_filter
// Kruskal edge filter that merges components through a union-find table.
// ----------------------------------------------------------------------------
//  Channel   Dir  Moves
//  edge_in   in   node_a, node_b, edge_weight request
//  res_out   out  accepted, root_a, root_b, tree_edges, total_cost, tree_complete
//  APB       in   vertex_count register at byte address 0
//
// A result follows the root walks of both endpoints of its edge request and
// the commit step; the next request can be taken as soon as the result is
// presented. The single read port of the parent table sets the walk to one
// link per cycle. An endpoint out of range skips its walk.
// Reset makes every table entry its own parent and clears count and cost.
// A stalled result holds the block in its commit step; the next edge request is
// taken while the previous result still waits.
// ----------------------------------------------------------------------------
module kruskal_union_find_edge_filter #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    kufef_edge_if.sink                        edge_in,
    kufef_result_if.source                    res_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [kufef_pkg::PADDR_W-1:0]     paddr,
    input  logic [kufef_pkg::PDATA_W-1:0]     pwdata,
    output logic [kufef_pkg::PDATA_W-1:0]     prdata,
    output logic                              pready
);
    import kufef_pkg::*;

    logic [VC_W-1:0] vc_reg;
    ctrl_cmd_t       cmd;
    dp_status_t      status;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= VC_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_VERTEX_COUNT))
        begin
            vc_reg <= pwdata[VC_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? PDATA_W'(vc_reg) : '0;

    kufef_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (edge_in.valid),
        .in_ready (edge_in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    kufef_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .vertex_count  (vc_reg),
        .node_a        (edge_in.node_a),
        .node_b        (edge_in.node_b),
        .edge_weight   (edge_in.edge_weight),
        .out_valid     (res_out.valid),
        .out_ready     (res_out.ready),
        .accepted      (res_out.accepted),
        .root_a        (res_out.root_a),
        .root_b        (res_out.root_b),
        .tree_edges    (res_out.tree_edges),
        .total_cost    (res_out.total_cost),
        .tree_complete (res_out.tree_complete)
    );

endmodule

[tb/sv/tb_kruskal_union_find_edge_filter.sv]
// ----------------------------------------------------------------------------
// tb_kruskal_union_find_edge_filter
// Self-checking bench for the union-find edge filter. Edge requests go in
// on the valid-ready channel, and a tracker keeps its own parent table,
// tree edge count and cost so that each returned result can be checked
// field by field. The vertex count register is written and read back over
// APB between phases, which step through clamped, small and full settings
// under changing idle patterns on both channels.
// ----------------------------------------------------------------------------
module tb_kruskal_union_find_edge_filter;
    import kufef_pkg::*;

    localparam int NODES             = 16;
    localparam int CYCLE_LIMIT       = 1_000_000;
    localparam int SETTLE_CYCLES     = 2 * NODES + 16;
    localparam int ITEMS_PER_SETTING = 88;
    localparam int NUM_SETTINGS      = 12;

    localparam logic [PADDR_W-1:0] VC_ADDR    = {REG_VERTEX_COUNT, 2'b00};
    localparam logic [PADDR_W-1:0] SPARE_ADDR = {~REG_VERTEX_COUNT, 2'b00};

    typedef struct packed {
        logic               accepted;
        logic [NODE_W-1:0]  root_a;
        logic [NODE_W-1:0]  root_b;
        logic [COUNT_W-1:0] tree_edges;
        logic [COST_W-1:0]  total_cost;
        logic               tree_complete;
    } filter_result_t;

    class mst_tracker;
        logic [NODE_W-1:0] parent [NODES];
        int unsigned       edges_taken;
        int unsigned       cost_total;
        logic [VC_W-1:0]   vertex_count;
        filter_result_t    pending_results [$];
        int unsigned       mismatches;

        function new();
            for (int i = 0; i < NODES; i++)
            begin
                parent[i] = NODE_W'(i);
            end
            edges_taken  = 0;
            cost_total   = 0;
            vertex_count = VC_RESET;
            mismatches   = 0;
        endfunction

        function int unsigned vertices_in_use();
            int unsigned n;
            n = 32'(vertex_count);
            if (n < 2)
            begin
                n = 2;
            end
            if (n > NODES)
            begin
                n = NODES;
            end
            return n;
        endfunction

        function bit spanning_done();
            return edges_taken >= vertices_in_use() - 1;
        endfunction

        function logic [NODE_W-1:0] root_of(logic [NODE_W-1:0] node);
            logic [NODE_W-1:0] cur;
            cur = node;
            for (int i = 0; i < NODES; i++)
            begin
                if (parent[cur] == cur)
                begin
                    break;
                end
                cur = parent[cur];
            end
            return cur;
        endfunction

        function void write_reg(logic index, logic [PDATA_W-1:0] value);
            if (index == REG_VERTEX_COUNT)
            begin
                vertex_count = value[VC_W-1:0];
            end
        endfunction

        function void note_edge(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                                logic [WEIGHT_W-1:0] w);
            filter_result_t r;
            int unsigned    n;
            bit             a_ok;
            bit             b_ok;
            n          = vertices_in_use();
            a_ok       = a < n;
            b_ok       = b < n;
            r.accepted = 1'b0;
            r.root_a   = a_ok ? root_of(a) : a;
            r.root_b   = b_ok ? root_of(b) : b;
            if (a_ok && b_ok && r.root_a != r.root_b && !spanning_done())
            begin
                parent[r.root_a] = r.root_b;
                r.accepted       = 1'b1;
                if (edges_taken < COUNT_MAX)
                begin
                    edges_taken++;
                end
                if (cost_total > COST_MAX - w)
                begin
                    cost_total = COST_MAX;
                end
                else
                begin
                    cost_total += w;
                end
            end
            r.tree_edges    = edges_taken[COUNT_W-1:0];
            r.total_cost    = cost_total[COST_W-1:0];
            r.tree_complete = spanning_done();
            pending_results.push_back(r);
        endfunction

        task report(string what);
            mismatches++;
            $display("MISMATCH: %s", what);
        endtask

        task check_result(filter_result_t got);
            filter_result_t want;
            if (pending_results.size() == 0)
            begin
                report($sformatf("result with no request waiting: %p", got));
                return;
            end
            want = pending_results.pop_front();
            if (got.accepted !== want.accepted)
            begin
                report($sformatf("accepted got %0b want %0b", got.accepted, want.accepted));
            end
            if (got.root_a !== want.root_a)
            begin
                report($sformatf("root_a got %0d want %0d", got.root_a, want.root_a));
            end
            if (got.root_b !== want.root_b)
            begin
                report($sformatf("root_b got %0d want %0d", got.root_b, want.root_b));
            end
            if (got.tree_edges !== want.tree_edges)
            begin
                report($sformatf("tree_edges got %0d want %0d",
                                 got.tree_edges, want.tree_edges));
            end
            if (got.total_cost !== want.total_cost)
            begin
                report($sformatf("total_cost got %0d want %0d",
                                 got.total_cost, want.total_cost));
            end
            if (got.tree_complete !== want.tree_complete)
            begin
                report($sformatf("tree_complete got %0b want %0b",
                                 got.tree_complete, want.tree_complete));
            end
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int unsigned cycles;
    mst_tracker  tracker = new();

    kufef_edge_if   edge_bus ();
    kufef_result_if res_bus ();

    kruskal_union_find_edge_filter #(
        .MAX_VERTICES(NODES)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .edge_in (edge_bus),
        .res_out (res_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        filter_result_t got;
        res_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_bus.valid && res_bus.ready)
            begin
                got.accepted      = res_bus.accepted;
                got.root_a        = res_bus.root_a;
                got.root_b        = res_bus.root_b;
                got.tree_edges    = res_bus.tree_edges;
                got.total_cost    = res_bus.total_cost;
                got.tree_complete = res_bus.tree_complete;
                tracker.check_result(got);
            end
            res_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic send_edge(input logic [NODE_W-1:0] a, input logic [NODE_W-1:0] b,
                             input logic [WEIGHT_W-1:0] w);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            edge_bus.valid <= 1'b0;
            @(posedge clk);
        end
        edge_bus.valid       <= 1'b1;
        edge_bus.node_a      <= a;
        edge_bus.node_b      <= b;
        edge_bus.edge_weight <= w;
        @(posedge clk);
        while (!edge_bus.ready)
        begin
            @(posedge clk);
        end
        tracker.note_edge(a, b, w);
    endtask

    task automatic drain_edges();
        edge_bus.valid <= 1'b0;
        while (tracker.pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        if (wr)
        begin
            tracker.write_reg(addr[PADDR_W-1], data);
        end
        else if (addr == VC_ADDR && prdata[VC_W-1:0] !== tracker.vertex_count)
        begin
            tracker.report($sformatf("vertex_count readback got %0d want %0d",
                                     prdata[VC_W-1:0], tracker.vertex_count));
        end
    endtask

    task automatic program_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        apb_access(1'b1, addr, data);
        apb_access(1'b0, VC_ADDR, '0);
    endtask

    task automatic bus_release();
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_random_edges(input int count);
        int unsigned       n;
        int unsigned       w;
        int unsigned       roll;
        logic [NODE_W-1:0] a;
        logic [NODE_W-1:0] b;
        logic [WEIGHT_W-1:0] w_sent;
        n = tracker.vertices_in_use();
        w = $urandom_range(0, 2000);
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                w += $urandom_range(0, 8191);
            end
            else
            begin
                w += $urandom_range(0, 255);
            end
            if (w > 65535)
            begin
                w = $urandom_range(0, 1023);
            end
            a    = NODE_W'($urandom_range(0, n - 1));
            b    = NODE_W'($urandom_range(0, n - 1));
            roll = $urandom_range(0, 99);
            if (roll < 15)
            begin
                a = NODE_W'($urandom_range(0, NODES - 1));
                b = NODE_W'($urandom_range(0, NODES - 1));
            end
            else if (roll < 22)
            begin
                b = a;
            end
            else if (roll < 40)
            begin
                b = a + 1'b1;
            end
            w_sent = ($urandom_range(0, 9) == 0) ? WEIGHT_W'($urandom()) : WEIGHT_W'(w);
            send_edge(a, b, w_sent);
        end
    endtask

    initial
    begin
        logic [PDATA_W-1:0] word;
        int                 settings [NUM_SETTINGS];
        int                 mode;
        settings = '{9, 10, 1, 12, 31, 16, 2, 0, 17, 5, 16, 0};
        settings[NUM_SETTINGS-1] = $urandom_range(0, 31);

        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        edge_bus.valid       = 1'b0;
        edge_bus.node_a      = '0;
        edge_bus.node_b      = '0;
        edge_bus.edge_weight = '0;
        tx_idle_pct          = 34;
        rx_idle_pct          = 51;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // A count of zero clamps to two vertices, so one merge completes the tree.
        apb_access(1'b0, VC_ADDR, '0);
        program_reg(VC_ADDR, 32'h0000_0000);
        bus_release();
        send_edge(4'd5, 4'd9, 16'h0000);
        send_edge(4'd0, 4'd15, 16'hFFFF);
        send_edge(4'd1, 4'd1, 16'h0001);
        send_edge(4'd1, 4'd0, 16'hFFFF);
        send_edge(4'd0, 4'd1, 16'h8000);
        drain_edges();

        program_reg(SPARE_ADDR, 32'h0000_0002);
        program_reg(VC_ADDR, 32'hFFFF_FFFF);
        bus_release();
        send_edge(4'd15, 4'd14, 16'h0000);
        send_edge(4'd14, 4'd15, 16'h0003);
        send_edge(4'd2, 4'd3, 16'h0004);
        send_edge(4'd3, 4'd4, 16'h0005);
        send_edge(4'd4, 4'd5, 16'h0006);
        send_edge(4'd2, 4'd5, 16'h0007);
        send_edge(4'd0, 4'd2, 16'h0008);
        send_edge(4'd1, 4'd4, 16'h0009);
        send_edge(4'd2, 4'd2, 16'hFFFF);
        drain_edges();

        // Lowering the count to seven completes the tree without a new merge.
        program_reg(VC_ADDR, 32'h0000_0007);
        bus_release();
        send_edge(4'd6, 4'd3, 16'h000A);
        send_edge(4'd9, 4'd2, 16'h000B);
        send_edge(4'd3, 4'd7, 16'h000C);

        for (int s = 0; s < NUM_SETTINGS; s++)
        begin
            drain_edges();
            mode = s / 4;
            tx_idle_pct = (mode == 0) ? 34 : ((mode == 1) ? 51 : 0);
            rx_idle_pct = (mode == 0) ? 51 : ((mode == 1) ? 34 : 0);
            word = $urandom();
            word[VC_W-1:0] = VC_W'(settings[s]);
            program_reg(VC_ADDR, word);
            bus_release();
            run_random_edges(ITEMS_PER_SETTING);
        end

        drain_edges();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.pending_results.size() != 0)
        begin
            tracker.report($sformatf("%0d results never arrived",
                                     tracker.pending_results.size()));
        end
        if (tracker.mismatches == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[sim.f]
src/kufef_pkg.sv
src/kufef_if.sv
src/kufef_ctrl.sv
src/kufef_dp.sv
src/kruskal_union_find_edge_filter.sv
tb/sv/tb_kruskal_union_find_edge_filter.sv
